// ===== design/smdsa_pkg.sv =====
// Package for the data stack ALU: opcodes, error codes, sequencer states,
// beat structs and default sizes. No dependencies.
`timescale 1ns / 1ps
package smdsa_pkg;

    localparam int STACK_CELLS_DEF = 64;
    localparam int CELL_BITS_DEF   = 32;

    typedef enum logic [5:0] {
        OP_DUP = 6'd0, OP_DROP = 6'd1, OP_SWAP = 6'd2, OP_OVER = 6'd3,
        OP_ROT = 6'd4, OP_NROT = 6'd5, OP_2DROP = 6'd6, OP_2DUP = 6'd7,
        OP_2SWAP = 6'd8, OP_QDUP = 6'd9, OP_INC1 = 6'd10, OP_DEC1 = 6'd11,
        OP_INC4 = 6'd12, OP_DEC4 = 6'd13, OP_ADD = 6'd14, OP_SUB = 6'd15,
        OP_MUL = 6'd16, OP_DIV = 6'd17, OP_MOD = 6'd18, OP_EQ = 6'd19,
        OP_NE = 6'd20, OP_LT = 6'd21, OP_GT = 6'd22, OP_LE = 6'd23,
        OP_GE = 6'd24, OP_ZEQ = 6'd25, OP_ZNE = 6'd26, OP_ZLT = 6'd27,
        OP_ZGT = 6'd28, OP_ZLE = 6'd29, OP_ZGE = 6'd30, OP_AND = 6'd31,
        OP_OR = 6'd32, OP_XOR = 6'd33, OP_INV = 6'd34, OP_LIT = 6'd35
    } t_opcode;

    typedef enum logic [1:0] {
        ERR_OK = 2'd0, ERR_UNDER = 2'd1, ERR_OVER = 2'd2, ERR_DIVZ = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_LOAD, ST_CHECK, ST_ITER, ST_WRITE, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MD_MUL, MD_DIV, MD_MOD
    } t_mdop;

    typedef struct packed {
        logic [5:0]         opcode;
        logic signed [31:0] literal;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [6:0]         depth;
        logic [1:0]         error_code;
    } t_out_beat;

endpackage

// ===== design/smdsa_muldiv.sv =====
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
// Depends on smdsa_pkg.
`timescale 1ns / 1ps
module smdsa_muldiv import smdsa_pkg::*; #(
    parameter int CELL_BITS = CELL_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_mdop                i_op,
    input  logic [CELL_BITS-1:0] i_a,
    input  logic [CELL_BITS-1:0] i_b,
    output logic                 o_done,
    output logic [CELL_BITS-1:0] o_result
);
    localparam int CW = $clog2(CELL_BITS + 1);

    logic                 r_busy, n_busy;
    logic [CW-1:0]        r_cnt, n_cnt;
    t_mdop                r_op, n_op;
    logic [CELL_BITS-1:0] r_acc, n_acc;
    logic [CELL_BITS-1:0] r_q, n_q;
    logic [CELL_BITS-1:0] r_b, n_b;
    logic                 r_neg, n_neg;
    logic [CELL_BITS:0]   w_rem;
    logic [CELL_BITS-1:0] w_ma, w_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_op  <= n_op;
        r_acc <= n_acc;
        r_q   <= n_q;
        r_b   <= n_b;
        r_neg <= n_neg;
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_acc  = r_acc;
        n_q    = r_q;
        n_b    = r_b;
        n_neg  = r_neg;
        o_done = 1'b0;
        w_ma   = i_a[CELL_BITS-1] ? (~i_a + 1'b1) : i_a;
        w_mb   = i_b[CELL_BITS-1] ? (~i_b + 1'b1) : i_b;
        w_rem  = {r_acc, r_q[CELL_BITS-1]} - {1'b0, r_b};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(CELL_BITS);
            n_op   = i_op;
            n_acc  = '0;
            if (i_op == MD_MUL) begin
                n_q   = i_a;
                n_b   = i_b;
                n_neg = 1'b0;
            end else begin
                n_q   = w_ma;
                n_b   = w_mb;
                n_neg = (i_op == MD_DIV) ? (i_a[CELL_BITS-1] ^ i_b[CELL_BITS-1])
                                         : i_a[CELL_BITS-1];
            end
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
                if (r_op == MD_MUL) begin
                    n_acc = (r_acc << 1) + (r_q[CELL_BITS-1] ? r_b : '0);
                    n_q   = r_q << 1;
                end else if (!w_rem[CELL_BITS]) begin
                    n_acc = w_rem[CELL_BITS-1:0];
                    n_q   = {r_q[CELL_BITS-2:0], 1'b1};
                end else begin
                    n_acc = {r_acc[CELL_BITS-2:0], r_q[CELL_BITS-1]};
                    n_q   = {r_q[CELL_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        case (r_op)
            MD_MUL:  o_result = r_acc;
            MD_DIV:  o_result = r_neg ? (~r_q + 1'b1) : r_q;
            MD_MOD:  o_result = r_neg ? (~r_acc + 1'b1) : r_acc;
            default: o_result = r_acc;
        endcase
    end
endmodule

// ===== design/stack_machine_data_stack_alu_top.sv =====
// Top level of the data stack ALU: stack memory, sequencer and ALU.
// Depends on smdsa_pkg and smdsa_muldiv.
`timescale 1ns / 1ps
// Usage: drive i_cmd and raise start while busy is low; the beat is taken
// at that edge. One result beat appears on o_result with o_done high for
// one cycle; the receiver cannot stall it.
// Sequence: each cell read takes two states (address, then load) through the
// single read port of the stack memory, then the check state runs, and the
// write state stores one cell per pass plus one closing pass. A last state
// fetches the top cell; on underflow the sequencer goes straight to it.
// Multiply, divide and mod run the shared one-bit-per-cycle unit between the
// check and write states.
// busy stays high from acceptance until the result cycle; a new beat can be
// taken at the edge that ends the result cycle, so one item is in flight
// at a time.
// Reset clears the depth count and the sequencer; the cell memory is not
// cleared since only values of cells below the depth are used.
// Errors (underflow, overflow, divide by zero) leave the stack unchanged.
module stack_machine_data_stack_alu_top import smdsa_pkg::*; #(
    parameter int STACK_CELLS = STACK_CELLS_DEF,
    parameter int CELL_BITS   = CELL_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_beat  i_cmd,
    output logic      o_done,
    output t_out_beat o_result
);
    localparam int AW = $clog2(STACK_CELLS);
    localparam int DW = $clog2(STACK_CELLS + 1);
    localparam int CB = CELL_BITS;

    logic [CB-1:0] r_mem [STACK_CELLS];

    t_state        r_state, n_state;
    logic [DW-1:0] r_cnt, n_cnt;
    logic [5:0]    r_op, n_op;
    logic [CB-1:0] r_lit, n_lit;
    logic [CB-1:0] r_c [4];
    logic [CB-1:0] n_c [4];
    logic [2:0]    r_k, n_k;
    logic [2:0]    r_need, n_need;
    logic [2:0]    r_nw, n_nw;
    logic [CB-1:0] r_rd;
    logic [1:0]    r_err, n_err;
    logic [CB-1:0] r_top, n_top;
    logic          r_done, n_done;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [CB-1:0] w_wdata;
    logic          w_md_start, w_md_done;
    t_mdop         w_md_op;
    logic [CB-1:0] w_md_res;
    logic [2:0]    w_need;
    logic [DW:0]   w_grow_cnt;
    logic [CB-1:0] w_a, w_b, w_r;
    logic          w_lt, w_gt, w_zlt, w_zgt;

    smdsa_muldiv #(.CELL_BITS(CB)) u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_md_start),
        .i_op    (w_md_op),
        .i_a     (r_c[1]),
        .i_b     (r_c[0]),
        .o_done  (w_md_done),
        .o_result(w_md_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        r_op   <= n_op;
        r_lit  <= n_lit;
        r_c    <= n_c;
        r_k    <= n_k;
        r_need <= n_need;
        r_nw   <= n_nw;
        r_err  <= n_err;
        r_top  <= n_top;
    end

    always_comb begin
        case (i_cmd.opcode) inside
            OP_LIT:                        w_need = 3'd0;
            OP_ROT, OP_NROT:               w_need = 3'd3;
            OP_2SWAP:                      w_need = 3'd4;
            OP_SWAP, OP_OVER, OP_2DROP, OP_2DUP,
            [OP_ADD:OP_GE], [OP_AND:OP_XOR]: w_need = 3'd2;
            OP_DUP, OP_DROP, OP_QDUP, [OP_INC1:OP_DEC4],
            [OP_ZEQ:OP_ZGE], OP_INV:       w_need = 3'd1;
            default:                       w_need = 3'd0;
        endcase
    end

    assign w_a   = r_c[1];
    assign w_b   = r_c[0];
    assign w_lt  = $signed(w_a) < $signed(w_b);
    assign w_gt  = $signed(w_b) < $signed(w_a);
    assign w_zlt = w_b[CB-1];
    assign w_zgt = !w_b[CB-1] && (w_b != '0);

    always_comb begin
        case (r_op) inside
            OP_ADD:  w_r = w_a + w_b;
            OP_SUB:  w_r = w_a - w_b;
            OP_EQ:   w_r = CB'(w_a == w_b);
            OP_NE:   w_r = CB'(w_a != w_b);
            OP_LT:   w_r = CB'(w_lt);
            OP_GT:   w_r = CB'(w_gt);
            OP_LE:   w_r = CB'(!w_gt);
            OP_GE:   w_r = CB'(!w_lt);
            OP_AND:  w_r = w_a & w_b;
            OP_OR:   w_r = w_a | w_b;
            OP_XOR:  w_r = w_a ^ w_b;
            OP_INC1: w_r = w_b + CB'(1);
            OP_DEC1: w_r = w_b - CB'(1);
            OP_INC4: w_r = w_b + CB'(4);
            OP_DEC4: w_r = w_b - CB'(4);
            OP_ZEQ:  w_r = CB'(w_b == '0);
            OP_ZNE:  w_r = CB'(w_b != '0);
            OP_ZLT:  w_r = CB'(w_zlt);
            OP_ZGT:  w_r = CB'(w_zgt);
            OP_ZLE:  w_r = CB'(!w_zgt);
            OP_ZGE:  w_r = CB'(!w_zlt);
            OP_INV:  w_r = ~w_b;
            default: w_r = w_b;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_op       = r_op;
        n_lit      = r_lit;
        n_c        = r_c;
        n_k        = r_k;
        n_need     = r_need;
        n_nw       = r_nw;
        n_err      = r_err;
        n_top      = r_top;
        n_done     = 1'b0;
        busy       = (r_state != ST_IDLE);
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = r_c[0];
        w_raddr    = AW'(r_cnt - DW'(1) - DW'(r_k));
        w_md_start = 1'b0;
        w_md_op    = MD_MUL;
        w_grow_cnt = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op   = i_cmd.opcode;
                    n_lit  = CB'(i_cmd.literal);
                    n_need = w_need;
                    n_k    = '0;
                    n_err  = ERR_OK;
                    n_state = (w_need == 3'd0) ? ST_CHECK : ST_READ;
                    if ({1'b0, r_cnt} < {1'b0, DW'(w_need)}) begin
                        n_err   = ERR_UNDER;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_c[r_k[1:0]] = r_rd;
                n_k = r_k + 3'd1;
                n_state = (r_k + 3'd1 == r_need) ? ST_CHECK : ST_READ;
            end
            ST_CHECK: begin
                n_k = '0;
                case (r_op) inside
                    OP_DUP, OP_OVER, OP_LIT: w_grow_cnt = {1'b0, r_cnt} + 1'b1;
                    OP_2DUP:                 w_grow_cnt = {1'b0, r_cnt} + 2'd2;
                    OP_QDUP: w_grow_cnt = {1'b0, r_cnt} + ((r_c[0] != '0) ? 1'b1 : 1'b0);
                    default:                 w_grow_cnt = {1'b0, r_cnt};
                endcase
                n_state = ST_WRITE;
                if (w_grow_cnt > (DW+1)'(STACK_CELLS)) begin
                    n_err   = ERR_OVER;
                    n_state = ST_DONE;
                end else if ((r_op == OP_DIV || r_op == OP_MOD) && r_c[0] == '0) begin
                    n_err   = ERR_DIVZ;
                    n_state = ST_DONE;
                end else if (r_op == OP_MUL || r_op == OP_DIV || r_op == OP_MOD) begin
                    w_md_start = 1'b1;
                    w_md_op = (r_op == OP_MUL) ? MD_MUL : ((r_op == OP_DIV) ? MD_DIV : MD_MOD);
                    n_state = ST_ITER;
                end else begin
                    case (r_op) inside
                        OP_DUP: begin
                            n_c[1] = r_c[0]; n_nw = 3'd1; n_cnt = r_cnt + 1'b1;
                        end
                        OP_OVER: begin
                            n_c[0] = r_c[1]; n_c[1] = r_c[0]; n_c[2] = r_c[1];
                            n_nw = 3'd1; n_cnt = r_cnt + 1'b1;
                        end
                        OP_LIT: begin
                            n_c[0] = r_lit; n_nw = 3'd1; n_cnt = r_cnt + 1'b1;
                        end
                        OP_QDUP: begin
                            n_nw = (r_c[0] != '0) ? 3'd1 : 3'd0;
                            n_cnt = (r_c[0] != '0) ? r_cnt + 1'b1 : r_cnt;
                        end
                        OP_2DUP: begin
                            n_c[2] = r_c[1]; n_c[3] = r_c[0];
                            n_c[1] = r_c[1]; n_c[0] = r_c[0];
                            n_nw = 3'd2; n_cnt = r_cnt + 2'd2;
                        end
                        OP_DROP: begin
                            n_nw = 3'd0; n_cnt = r_cnt - 1'b1; n_c[0] = r_c[1];
                        end
                        OP_2DROP: begin
                            n_nw = 3'd0; n_cnt = r_cnt - 2'd2;
                        end
                        OP_SWAP: begin
                            n_c[0] = r_c[1]; n_c[1] = r_c[0]; n_nw = 3'd2;
                        end
                        OP_ROT: begin
                            n_c[0] = r_c[2]; n_c[1] = r_c[0]; n_c[2] = r_c[1];
                            n_nw = 3'd3;
                        end
                        OP_NROT: begin
                            n_c[0] = r_c[1]; n_c[1] = r_c[2]; n_c[2] = r_c[0];
                            n_nw = 3'd3;
                        end
                        OP_2SWAP: begin
                            n_c[0] = r_c[2]; n_c[1] = r_c[3];
                            n_c[2] = r_c[0]; n_c[3] = r_c[1];
                            n_nw = 3'd4;
                        end
                        [OP_ADD:OP_SUB], [OP_EQ:OP_GE], [OP_AND:OP_XOR]: begin
                            n_c[0] = w_r; n_nw = 3'd1; n_cnt = r_cnt - 1'b1;
                        end
                        [OP_INC1:OP_DEC4], [OP_ZEQ:OP_INV]: begin
                            n_c[0] = w_r; n_nw = 3'd1;
                        end
                        default: begin
                            n_nw = 3'd0;
                        end
                    endcase
                end
            end
            ST_ITER: begin
                if (w_md_done) begin
                    n_c[0] = w_md_res;
                    n_nw = 3'd1;
                    n_cnt = r_cnt - 1'b1;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (r_k == r_nw) begin
                    n_state = ST_DONE;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_cnt - DW'(1) - DW'(r_k));
                    w_wdata = r_c[r_k[1:0]];
                    n_k     = r_k + 3'd1;
                end
            end
            ST_DONE: begin
                // The top cell of the result is fetched with one last memory read.
                w_raddr = AW'(r_cnt - DW'(1));
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_done              = r_done;
    assign o_result.top_value  = (r_cnt == '0) ? '0 : 32'(signed'(r_rd));
    assign o_result.depth      = 7'(r_cnt);
    assign o_result.error_code = r_err;

    ap_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted command");
    ap_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DW'(STACK_CELLS))
        else $error("stack depth exceeds capacity");
    ap_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while still busy");
endmodule
